/* hw/rtl/sbpa_pkg.sv */
// ----------------------------------------------------------------------------
// sbpa_pkg
// Shared codes, widths and control types of the block pool allocator.
// ----------------------------------------------------------------------------
package sbpa_pkg;

  localparam int NUM_POOLS = 4;
  localparam int PW        = 2;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_SIZE  = 2'd2;
  localparam logic [1:0] OP_STATS = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE   = 3'd1;
  localparam logic [2:0] ST_FULL        = 3'd2;
  localparam logic [2:0] ST_NOT_IN_POOL = 3'd3;
  localparam logic [2:0] ST_BAD_ADDR    = 3'd4;
  localparam logic [2:0] ST_DOUBLE_FREE = 3'd5;

  localparam logic [13:0] COUNT_RST [NUM_POOLS] = '{14'd4500, 14'd900, 14'd350, 14'd50};

  localparam int IN_DW  = 72;
  localparam int OUT_DW = 152;

  typedef struct packed {
    logic capture;
    logic decide;
    logic commit;
  } sbpa_cmd_t;

endpackage

/* hw/rtl/sbpa_ram.sv */
// ----------------------------------------------------------------------------
// sbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/sbpa_ctrl.sv */
// ----------------------------------------------------------------------------
// sbpa_ctrl
// Sequencer: capture a beat, decide, commit into the output register.
// ----------------------------------------------------------------------------
module sbpa_ctrl
  import sbpa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output sbpa_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_DECIDE, S_COMMIT} state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_tready   = (state_r == S_IDLE);
  assign out_tvalid  = out_valid_r;
  assign cmd.capture = in_tvalid && (state_r == S_IDLE);
  assign cmd.decide  = (state_r == S_DECIDE);
  assign cmd.commit  = (state_r == S_COMMIT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE:   if (in_tvalid) state_r <= S_DECIDE;
        S_DECIDE: state_r <= S_COMMIT;
        S_COMMIT: if (cmd.commit) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r) else $error("commit lost");
  a_decide_next: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DECIDE |=> state_r == S_COMMIT) else $error("decide stalled");
  a_capture_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.decide) else $error("capture not followed by decide");

endmodule

/* hw/rtl/sbpa_dp.sv */
// ----------------------------------------------------------------------------
// sbpa_dp
// Datapath: pool registers, counters, free index ring and output register.
// ----------------------------------------------------------------------------
module sbpa_dp
  import sbpa_pkg::*;
#(
  parameter int MAX_BLOCKS  = 8192,
  parameter int SHIFT_POOL0 = 6,
  parameter int SHIFT_POOL1 = 8,
  parameter int SHIFT_POOL2 = 10,
  parameter int SHIFT_POOL3 = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sbpa_cmd_t         cmd,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic [1:0]        in_tuser,
  output logic [OUT_DW-1:0] out_tdata,
  input  logic              cfg_wr,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int SW = $clog2(MAX_BLOCKS + 2);
  localparam int AW = CW + PW;
  localparam int SH [NUM_POOLS] = '{SHIFT_POOL0, SHIFT_POOL1, SHIFT_POOL2, SHIFT_POOL3};

  typedef enum logic [1:0] {ACT_NONE, ACT_ALLOC, ACT_FULL, ACT_FREE} act_t;

  logic [31:0] base_r  [NUM_POOLS];
  logic [13:0] count_r [NUM_POOLS];
  logic [CW-1:0] head_r [NUM_POOLS];
  logic [CW-1:0] use_r  [NUM_POOLS];
  logic [CW-1:0] peak_r [NUM_POOLS];
  logic [SW-1:0] wr_r   [NUM_POOLS];
  logic [31:0]   alloc_r[NUM_POOLS];
  logic [31:0]   full_r [NUM_POOLS];

  logic [CW-1:0] head_nxt [NUM_POOLS];
  logic [CW-1:0] use_nxt  [NUM_POOLS];
  logic [CW-1:0] peak_nxt [NUM_POOLS];
  logic [SW-1:0] wr_nxt   [NUM_POOLS];
  logic [31:0]   alloc_nxt[NUM_POOLS];
  logic [31:0]   full_nxt [NUM_POOLS];

  logic [1:0]  op_r;
  logic [31:0] size_r, addr_r;
  logic [1:0]  sel_r;

  logic [CW-1:0] eff [NUM_POOLS];
  logic [16:0]   blk [NUM_POOLS];
  logic [31:0]   off [NUM_POOLS];
  logic [31:0]   bidx[NUM_POOLS];
  logic fit [NUM_POOLS];
  logic avail [NUM_POOLS];
  logic inr [NUM_POOLS];
  logic algn [NUM_POOLS];

  act_t          d_act, act_r;
  logic [PW-1:0] d_pool, pool_r;
  logic          d_has, has_r;
  logic [2:0]    d_status, status_r;
  logic [CW-1:0] d_h, h_r;
  logic          d_hv, hv_r;
  logic [CW:0]   d_t;
  logic          ram_we;

  logic [IW-1:0] rdata;
  logic [IW-1:0] g_idx;
  logic [31:0]   g_addr;
  logic [CW:0]   h_inc;
  logic [OUT_DW-1:0] out_nxt;

  always_comb begin
    for (int p = 0; p < NUM_POOLS; p++) begin
      eff[p]   = (32'(count_r[p]) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(count_r[p]);
      blk[p]   = 17'(1) << SH[p];
      fit[p]   = size_r <= 32'(blk[p]);
      avail[p] = use_r[p] < eff[p];
      off[p]   = addr_r - base_r[p];
      bidx[p]  = off[p] >> SH[p];
      inr[p]   = (addr_r >= base_r[p]) && (bidx[p] < 32'(eff[p]));
      algn[p]  = (off[p] & (32'(blk[p]) - 32'd1)) == 32'd0;
    end
  end

  always_comb begin
    d_act    = ACT_NONE;
    d_pool   = '0;
    d_has    = 1'b0;
    d_status = ST_OK;
    case (op_r)
      OP_ALLOC: begin
        d_status = ST_TOO_LARGE;
        for (int p = NUM_POOLS - 1; p >= 0; p--) begin
          if (fit[p]) begin
            d_pool   = PW'(p);
            d_has    = 1'b1;
            d_status = ST_FULL;
            d_act    = ACT_FULL;
          end
        end
        for (int p = NUM_POOLS - 1; p >= 0; p--) begin
          if (fit[p] && avail[p]) begin
            d_pool   = PW'(p);
            d_status = ST_OK;
            d_act    = ACT_ALLOC;
          end
        end
      end
      OP_FREE, OP_SIZE: begin
        d_status = ST_NOT_IN_POOL;
        for (int p = NUM_POOLS - 1; p >= 0; p--) begin
          if (inr[p]) begin
            d_pool = PW'(p);
            d_has  = 1'b1;
          end
        end
        if (d_has) begin
          if (!algn[d_pool]) begin
            d_status = ST_BAD_ADDR;
          end else if (op_r == OP_SIZE) begin
            d_status = ST_OK;
          end else if (use_r[d_pool] == '0) begin
            d_status = ST_DOUBLE_FREE;
          end else begin
            d_status = ST_OK;
            d_act    = ACT_FREE;
          end
        end
      end
      default: begin
        d_pool = sel_r;
        d_has  = 1'b1;
      end
    endcase
  end

  // ring slot to pop, whether it was written since refill, and push slot
  always_comb begin
    d_h  = (head_r[d_pool] <= eff[d_pool]) ? head_r[d_pool] : '0;
    d_hv = (d_h == eff[d_pool]) ? (wr_r[d_pool] != '0)
                                : ((SW'(d_h) + SW'(1)) < wr_r[d_pool]);
    d_t  = (CW+1)'(head_r[d_pool]) + (CW+1)'(eff[d_pool] - use_r[d_pool]);
    if (d_t > (CW+1)'(eff[d_pool])) d_t = d_t - ((CW+1)'(eff[d_pool]) + (CW+1)'(1));
    if (d_t > (CW+1)'(eff[d_pool])) d_t = '0;
  end

  assign ram_we = cmd.decide && (d_act == ACT_FREE);

  sbpa_ram #(.WIDTH(IW), .DEPTH(NUM_POOLS << CW)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'({d_pool, d_t[CW-1:0]})),
    .wdata (bidx[d_pool][IW-1:0]),
    .raddr (AW'({d_pool, d_h})),
    .rdata (rdata)
  );

  assign g_idx  = hv_r ? rdata : h_r[IW-1:0];
  assign g_addr = base_r[pool_r] + (32'(g_idx) << SH[pool_r]);
  assign h_inc  = (CW+1)'(h_r) + (CW+1)'(1);

  always_comb begin
    for (int p = 0; p < NUM_POOLS; p++) begin
      head_nxt[p]  = head_r[p];
      use_nxt[p]   = use_r[p];
      peak_nxt[p]  = peak_r[p];
      wr_nxt[p]    = wr_r[p];
      alloc_nxt[p] = alloc_r[p];
      full_nxt[p]  = full_r[p];
    end
    case (act_r)
      ACT_ALLOC: begin
        head_nxt[pool_r]  = (h_inc > (CW+1)'(eff[pool_r])) ? '0 : h_inc[CW-1:0];
        use_nxt[pool_r]   = use_r[pool_r] + CW'(1);
        alloc_nxt[pool_r] = alloc_r[pool_r] + 32'd1;
        if (use_nxt[pool_r] > peak_r[pool_r]) peak_nxt[pool_r] = use_nxt[pool_r];
      end
      ACT_FULL: begin
        if (use_r[pool_r] == eff[pool_r]) full_nxt[pool_r] = full_r[pool_r] + 32'd1;
      end
      ACT_FREE: begin
        use_nxt[pool_r] = use_r[pool_r] - CW'(1);
        if (wr_r[pool_r] <= SW'(eff[pool_r])) wr_nxt[pool_r] = wr_r[pool_r] + SW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    out_nxt      = '0;
    out_nxt[2:0] = status_r;
    if (act_r == ACT_ALLOC) out_nxt[34:3] = g_addr;
    if (has_r) begin
      out_nxt[51:35]   = blk[pool_r];
      out_nxt[53:52]   = pool_r;
      out_nxt[67:54]   = 14'(use_nxt[pool_r]);
      out_nxt[81:68]   = 14'(peak_nxt[pool_r]);
      out_nxt[113:82]  = alloc_nxt[pool_r];
      out_nxt[145:114] = full_nxt[pool_r];
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      3'd0, 3'd1, 3'd2, 3'd3: cfg_prdata = base_r[cfg_paddr[3:2]];
      default:                cfg_prdata = 32'(count_r[cfg_paddr[3:2]]);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        base_r[p]  <= '0;
        count_r[p] <= COUNT_RST[p];
        head_r[p]  <= '0;
        use_r[p]   <= '0;
        peak_r[p]  <= '0;
        wr_r[p]    <= '0;
        alloc_r[p] <= '0;
        full_r[p]  <= '0;
      end
    end else begin
      if (cmd.commit) begin
        for (int p = 0; p < NUM_POOLS; p++) begin
          head_r[p]  <= head_nxt[p];
          use_r[p]   <= use_nxt[p];
          peak_r[p]  <= peak_nxt[p];
          wr_r[p]    <= wr_nxt[p];
          alloc_r[p] <= alloc_nxt[p];
          full_r[p]  <= full_nxt[p];
        end
      end
      if (cfg_wr) begin
        if (!cfg_paddr[4]) begin
          base_r[cfg_paddr[3:2]] <= cfg_pwdata;
        end else begin
          count_r[cfg_paddr[3:2]] <= cfg_pwdata[13:0];
          head_r[cfg_paddr[3:2]]  <= '0;
          use_r[cfg_paddr[3:2]]   <= '0;
          wr_r[cfg_paddr[3:2]]    <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_tuser;
      size_r <= in_tdata[31:0];
      addr_r <= in_tdata[63:32];
      sel_r  <= in_tdata[65:64];
    end
    if (cmd.decide) begin
      act_r    <= d_act;
      pool_r   <= d_pool;
      has_r    <= d_has;
      status_r <= d_status;
      h_r      <= d_h;
      hv_r     <= d_hv;
    end
    if (cmd.commit) begin
      out_tdata <= out_nxt;
    end
  end

endmodule

/* hw/rtl/segregated_block_pool_allocator.sv */
// ----------------------------------------------------------------------------
// segregated_block_pool_allocator
// Four fixed-block pools with free index rings, stream in and out, APB setup.
// ----------------------------------------------------------------------------
// A beat is captured, decided and committed into the output register; commit
// waits while an earlier result is held there. No new beat is taken before commit.
// The next input beat is taken while a result still waits in the output register.
// Reset: synchronous, active low; counters cleared, counts 4500/900/350/50.
// No clearing pass: untouched ring entries read as their own index.
module segregated_block_pool_allocator
  import sbpa_pkg::*;
#(
  parameter int MAX_BLOCKS  = 8192,
  parameter int SHIFT_POOL0 = 6,
  parameter int SHIFT_POOL1 = 8,
  parameter int SHIFT_POOL2 = 10,
  parameter int SHIFT_POOL3 = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // request_size[31:0], block_address[63:32], pool_select[65:64]
  input  logic [IN_DW-1:0]  in_tdata,
  // opcode[1:0]
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // status[2:0], granted_address[34:3], pool_block_size[51:35],
  // pool_number[53:52], blocks_in_use[67:54], peak_in_use[81:68],
  // allocations_total[113:82], exhausted_events[145:114]
  output logic [OUT_DW-1:0] out_tdata,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  sbpa_cmd_t cmd;

  assign cfg_pready = 1'b1;

  sbpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sbpa_dp #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .SHIFT_POOL0 (SHIFT_POOL0),
    .SHIFT_POOL1 (SHIFT_POOL1),
    .SHIFT_POOL2 (SHIFT_POOL2),
    .SHIFT_POOL3 (SHIFT_POOL3)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tdata  (out_tdata),
    .cfg_wr     (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata)
  );

endmodule

/* tb/sv/sbpa_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbpa_checker
// Watches the request, result and register ports of the pool allocator,
// keeps its own copy of the pools and compares every result beat with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module sbpa_checker
  import sbpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [IN_DW-1:0]   in_tdata,
  input  logic [1:0]         in_tuser,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [OUT_DW-1:0]  out_tdata,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 pending,
  output int                 errors
);

  localparam int MAXB = 8192;
  localparam int BLK_SHIFT [NUM_POOLS] = '{6, 8, 10, 12};

  typedef struct packed {
    logic [31:0] exhausted;
    logic [31:0] allocs;
    logic [13:0] peak;
    logic [13:0] in_use;
    logic [1:0]  pool;
    logic [16:0] blk_size;
    logic [31:0] grant;
    logic [2:0]  status;
  } pool_result_t;

  logic [31:0] base_q [NUM_POOLS];
  logic [13:0] count_q [NUM_POOLS];
  logic [13:0] free_ring [NUM_POOLS][MAXB+1];
  int unsigned head_q [NUM_POOLS];
  int unsigned used_q [NUM_POOLS];
  int unsigned peak_q [NUM_POOLS];
  logic [31:0] allocs_q [NUM_POOLS];
  logic [31:0] full_q [NUM_POOLS];

  pool_result_t results_due [$];

  function automatic int unsigned usable(int p);
    return (count_q[p] > MAXB) ? MAXB : count_q[p];
  endfunction

  function automatic void refill(int p);
    for (int i = 0; i <= MAXB; i++) free_ring[p][i] = i[13:0];
    head_q[p] = 0;
    used_q[p] = 0;
  endfunction

  function automatic void pool_fields(ref pool_result_t r, input int p);
    r.blk_size  = 17'(1 << BLK_SHIFT[p]);
    r.pool      = p[1:0];
    r.in_use    = used_q[p][13:0];
    r.peak      = peak_q[p][13:0];
    r.allocs    = allocs_q[p];
    r.exhausted = full_q[p];
  endfunction

  function automatic pool_result_t serve(logic [1:0] op, logic [31:0] size,
                                         logic [31:0] addr, logic [1:0] sel);
    pool_result_t r;
    int unsigned cnt, h, t, idx;
    logic [31:0] off;
    int hit;
    logic aligned;
    r = '0;
    hit = -1;
    aligned = 1'b0;
    idx = 0;
    if (op == OP_ALLOC) begin
      for (int p = 0; p < NUM_POOLS && hit < 0; p++) begin
        cnt = usable(p);
        if (size <= (32'd1 << BLK_SHIFT[p]) && used_q[p] < cnt) begin
          hit = p;
          h = (head_q[p] <= cnt) ? head_q[p] : 0;
          r.grant = base_q[p] + (32'(free_ring[p][h]) << BLK_SHIFT[p]);
          h++;
          if (h > cnt) h = 0;
          head_q[p] = h;
          used_q[p]++;
          allocs_q[p]++;
          if (used_q[p] > peak_q[p]) peak_q[p] = used_q[p];
          r.status = ST_OK;
          pool_fields(r, p);
        end
      end
      for (int p = 0; p < NUM_POOLS && hit < 0; p++) begin
        if (size <= (32'd1 << BLK_SHIFT[p])) begin
          hit = p;
          if (used_q[p] == usable(p)) full_q[p]++;
          r.status = ST_FULL;
          pool_fields(r, p);
        end
      end
      if (hit < 0) r.status = ST_TOO_LARGE;
    end else if (op == OP_FREE || op == OP_SIZE) begin
      for (int p = 0; p < NUM_POOLS && hit < 0; p++) begin
        if (addr >= base_q[p]) begin
          off = addr - base_q[p];
          if ((off >> BLK_SHIFT[p]) < usable(p)) begin
            hit = p;
            idx = off >> BLK_SHIFT[p];
            aligned = (off & ((32'd1 << BLK_SHIFT[p]) - 1)) == 0;
          end
        end
      end
      if (hit < 0) begin
        r.status = ST_NOT_IN_POOL;
      end else begin
        if (!aligned) begin
          r.status = ST_BAD_ADDR;
        end else if (op == OP_SIZE) begin
          r.status = ST_OK;
        end else if (used_q[hit] == 0) begin
          r.status = ST_DOUBLE_FREE;
        end else begin
          cnt = usable(hit);
          t = head_q[hit] + (cnt - used_q[hit]);
          if (t > cnt) t -= cnt + 1;
          if (t > cnt) t = 0;
          free_ring[hit][t] = idx[13:0];
          used_q[hit]--;
          r.status = ST_OK;
        end
        pool_fields(r, hit);
      end
    end else begin
      r.status = ST_OK;
      pool_fields(r, sel);
    end
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    pool_result_t got, want;
    if (!rst_n) begin
      for (int p = 0; p < NUM_POOLS; p++) begin
        base_q[p] = '0;
        count_q[p] = COUNT_RST[p];
        refill(p);
        peak_q[p] = 0;
        allocs_q[p] = '0;
        full_q[p] = '0;
      end
      results_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[4:2] < 4) begin
          base_q[cfg_paddr[3:2]] = cfg_pwdata;
        end else begin
          count_q[cfg_paddr[3:2]] = cfg_pwdata[13:0];
          refill(cfg_paddr[3:2]);
        end
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[145:0];
        if (results_due.size() == 0) begin
          report("unexpected beat, status", got.status, '0);
        end else begin
          want = results_due.pop_front();
          if (got.status != want.status) report("status", got.status, want.status);
          if (got.grant != want.grant) report("granted_address", got.grant, want.grant);
          if (got.blk_size != want.blk_size)
            report("pool_block_size", got.blk_size, want.blk_size);
          if (got.pool != want.pool) report("pool_number", got.pool, want.pool);
          if (got.in_use != want.in_use) report("blocks_in_use", got.in_use, want.in_use);
          if (got.peak != want.peak) report("peak_in_use", got.peak, want.peak);
          if (got.allocs != want.allocs)
            report("allocations_total", got.allocs, want.allocs);
          if (got.exhausted != want.exhausted)
            report("exhausted_events", got.exhausted, want.exhausted);
        end
      end
      if (in_tvalid && in_tready)
        results_due.push_back(serve(in_tuser, in_tdata[31:0], in_tdata[63:32],
                                    in_tdata[65:64]));
    end
    pending = results_due.size();
  end

endmodule

/* tb/sv/segregated_block_pool_allocator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segregated_block_pool_allocator_test
// Drives allocate, release, size and statistics requests through the pool
// allocator over several pool layouts, with bursty requests and a stalling
// result side; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module segregated_block_pool_allocator_test;
  import sbpa_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int BLK_SHIFT [NUM_POOLS] = '{6, 8, 10, 12};

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic [1:0]        in_tuser = OP_ALLOC;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [4:0]        cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;
  int                pending;
  int                errors;
  int                idle_cycles = 0;
  int                burst_left = 0;
  int unsigned       stall_cyc = 0;
  logic [31:0]       layout_base [NUM_POOLS];
  int unsigned       layout_count [NUM_POOLS];

  always #1 clk = ~clk;

  segregated_block_pool_allocator uut (.*);

  sbpa_checker chk (.*);

  always @(negedge clk) begin
    stall_cyc++;
    case ((stall_cyc / 300) % 3)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= (stall_cyc % 7) > 2;
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic reg_write(int idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = 5'(idx * 4);
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (idx < 4) layout_base[idx] = value;
    else layout_count[idx-4] = value[13:0];
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid = 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_layout(logic [31:0] b0, b1, b2, b3, int c0, c1, c2, c3);
    drain();
    reg_write(0, b0);
    reg_write(1, b1);
    reg_write(2, b2);
    reg_write(3, b3);
    reg_write(4, c0);
    reg_write(5, c1);
    reg_write(6, c2);
    reg_write(7, c3);
  endtask

  task automatic send(logic [1:0] op, logic [31:0] size, logic [31:0] addr,
                      logic [1:0] sel);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid = 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {6'b0, sel, addr, size};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  function automatic logic [31:0] pick_size();
    int k;
    k = $urandom_range(0, 3);
    if ($urandom_range(0, 11) == 0) return $urandom();
    if (k == 0) return $urandom_range(0, 64);
    return $urandom_range((1 << BLK_SHIFT[k-1]) + 1, 1 << BLK_SHIFT[k]);
  endfunction

  function automatic logic [31:0] pick_addr();
    int p, r;
    logic [31:0] a;
    p = $urandom_range(0, 3);
    r = $urandom_range(0, 9);
    a = layout_base[p] + ($urandom_range(0, layout_count[p]) << BLK_SHIFT[p]);
    if (r == 7) a += $urandom_range(1, (1 << BLK_SHIFT[p]) - 1);
    if (r > 7) a = $urandom();
    return a;
  endfunction

  task automatic random_ops(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 42) send(OP_ALLOC, pick_size(), $urandom(), $urandom());
      else if (r < 77) send(OP_FREE, $urandom(), pick_addr(), $urandom());
      else if (r < 89) send(OP_SIZE, $urandom(), pick_addr(), $urandom());
      else send(OP_STATS, $urandom(), $urandom(), $urandom());
    end
  endtask

  initial begin
    for (int p = 0; p < NUM_POOLS; p++) begin
      layout_base[p] = '0;
      layout_count[p] = COUNT_RST[p];
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < NUM_POOLS; p++) send(OP_STATS, '0, '0, p);
    send(OP_ALLOC, 32'd0, '0, '0);
    send(OP_ALLOC, 32'd64, '0, '0);
    send(OP_ALLOC, 32'd65, '0, '0);
    send(OP_ALLOC, 32'd4096, '0, '0);
    send(OP_ALLOC, 32'd4097, '0, '0);
    send(OP_ALLOC, 32'hFFFF_FFFF, '0, '0);
    send(OP_SIZE, '0, 32'd0, '0);
    send(OP_SIZE, '0, 32'd1, '0);
    send(OP_SIZE, '0, 32'hFFFF_FFFF, '0);
    send(OP_FREE, '0, 32'd64, '0);
    send(OP_FREE, '0, 32'd0, '0);
    send(OP_FREE, '0, 32'd0, '0);
    send(OP_FREE, '0, 32'd3, '0);

    // tiny pools: exhaust, release, double release
    set_layout(32'h1000_0000, 32'h2000_0000, 32'h3000_0000, 32'hFFFF_F000, 2, 1, 1, 1);
    repeat (6) send(OP_ALLOC, 32'd1, '0, '0);
    send(OP_FREE, '0, 32'hFFFF_F000, '0);
    send(OP_FREE, '0, 32'hFFFF_F000, '0);
    send(OP_ALLOC, 32'd4000, '0, '0);
    for (int p = 0; p < NUM_POOLS; p++) send(OP_STATS, '0, '0, p);

    set_layout(32'h1000_0000, 32'h2000_0000, 32'h3000_0000, 32'h4000_0000, 8, 4, 3, 2);
    random_ops(260);
    set_layout(32'h0, 32'h200, 32'h800, 32'h2000, 1, 1, 1, 1);
    random_ops(200);
    set_layout(32'hFFFF_FFC0, 32'h8000_0000, 32'h5555_5400, 32'hFFFF_F000,
               8192, 16383, 0, 5);
    random_ops(220);
    set_layout($urandom(), $urandom(), $urandom(), $urandom(),
               $urandom_range(1, 16), $urandom_range(1, 16),
               $urandom_range(1, 16), $urandom_range(1, 16));
    random_ops(260);
    set_layout(32'h0, 32'h0, 32'h0, 32'h0, $urandom_range(0, 12), $urandom_range(0, 12),
               $urandom_range(0, 12), $urandom_range(0, 12));
    random_ops(260);
    set_layout(32'h0, 32'h1_0000, 32'h4_0000, 32'h10_0000, 12, 6, 4, 3);
    random_ops(310);

    @(negedge clk);
    in_tvalid = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
